@@ hdl/htp_pkg.sv @@
// Shared types, constants and character classes for the hex token parser.
package htp_pkg;

  localparam int unsigned DEF_MAX_BYTES = 8;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned CNT_W         = 4;
  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 4;

  localparam logic [CNT_W-1:0] RST_BYTE_LIMIT   = 4'd8;
  localparam logic             RST_FIXED_LENGTH = 1'b1;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CH_W-1:0] CH_RBRK  = 8'h5D;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UF    = 8'h46;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LF    = 8'h66;
  localparam logic [CH_W-1:0] HEX_TEN  = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BYTE_LIMIT   = 2'd0,
    REG_FIXED_LENGTH = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_e;

  typedef struct packed {
    logic               ok;
    logic [CNT_W-1:0]   bytes_parsed;
    logic [VALUE_W-1:0] value;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nib;
  } hex_t;

  function automatic logic is_ws(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_term(input logic [CH_W-1:0] c);
    return (c == CH_NUL) || is_ws(c) || (c == CH_SEMI) || (c == CH_RBRK) ||
           (c == CH_SLASH);
  endfunction

  function automatic hex_t hex_decode(input logic [CH_W-1:0] c);
    hex_t h;
    logic [CH_W-1:0] t;
    h = '0;
    t = '0;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      t = c - CH_ZERO;
      h = '{valid: 1'b1, nib: t[3:0]};
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      t = c - CH_UA + HEX_TEN;
      h = '{valid: 1'b1, nib: t[3:0]};
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      t = c - CH_LA + HEX_TEN;
      h = '{valid: 1'b1, nib: t[3:0]};
    end
    return h;
  endfunction

endpackage

@@ hdl/hex_token_parser_top.sv @@
// Top level of the hex token parser: input register, token state, result queue.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------
//  in      | in_valid_i / in_stall_o    | ch_i
//  out     | out_valid_o / out_stall_i  | ok_o, bytes_parsed_o, value_o
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One word per cycle while in_stall_o is low. A word is held in the input
// register, its token update and any result are formed there, and the result
// is written to the output register, or to the skid entry while that is held.
// A two-entry result queue (output register plus skid) lets words flow while
// one result waits; the input stalls only when both entries are full.
// Reset clears the token state, the queue and restores byte_limit 8, fixed 1.
module hex_token_parser_top
  import htp_pkg::*;
#(
  parameter int unsigned MAX_BYTES = DEF_MAX_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CH_W-1:0]       ch_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  ok_o,
  output logic [CNT_W-1:0]      bytes_parsed_o,
  output logic [VALUE_W-1:0]    value_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned BUF_W = 8 * MAX_BYTES;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

  // configuration
  logic [CNT_W-1:0] byte_limit_q;
  logic             fixed_length_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_limit_q   <= RST_BYTE_LIMIT;
      fixed_length_q <= RST_FIXED_LENGTH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BYTE_LIMIT:   byte_limit_q   <= cfg_data_i[CNT_W-1:0];
        REG_FIXED_LENGTH: fixed_length_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic            chv_q;
  logic [CH_W-1:0] ch_q;
  logic            sv_q;
  logic            ov_q;
  logic            advance;

  assign advance    = chv_q && !sv_q;
  assign in_stall_o = chv_q && sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chv_q <= 1'b0;
    end else if (!in_stall_o) begin
      chv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ch_q <= ch_i;
    end
  end

  // token state
  phase_e           phase_q, phase_d;
  logic [3:0]       high_q, high_d;
  logic [CNT_W-1:0] done_q, done_d;
  logic [BUF_W-1:0] buf_q, buf_d;

  hex_t             hx;
  logic [CNT_W-1:0] lim;
  logic             count_ok;
  logic             emit;
  logic             good;
  res_t             res_new;

  always_comb begin
    hx       = hex_decode(ch_q);
    lim      = (byte_limit_q > MAX_CNT) ? MAX_CNT : byte_limit_q;
    count_ok = (done_q >= lim) || (!fixed_length_q && (done_q != '0));
    phase_d  = phase_q;
    high_d   = high_q;
    done_d   = done_q;
    buf_d    = buf_q;
    emit     = 1'b0;
    good     = 1'b0;
    case (phase_q)
      PH_LOW: begin
        if (!hx.valid) begin
          emit = 1'b1;
        end else begin
          buf_d   = BUF_W'({buf_q, high_q, hx.nib});
          done_d  = done_q + 1'b1;
          phase_d = PH_HIGH;
        end
      end
      PH_SKIP, PH_HIGH: begin
        if (!((phase_q == PH_SKIP) && is_ws(ch_q))) begin
          phase_d = PH_HIGH;
          if ((done_q >= lim) || !hx.valid) begin
            emit = 1'b1;
            good = 1'b1;
          end else begin
            high_d  = hx.nib;
            phase_d = PH_LOW;
          end
        end
      end
      default: phase_d = PH_SKIP;
    endcase
    res_new = '0;
    if (emit) begin
      // drop the token and restart on the ending character
      phase_d = PH_SKIP;
      high_d  = '0;
      done_d  = '0;
      buf_d   = '0;
      if (good && count_ok && is_term(ch_q)) begin
        res_new = '{ok: 1'b1, bytes_parsed: done_q, value: VALUE_W'(buf_q)};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      high_q  <= '0;
      done_q  <= '0;
      buf_q   <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      high_q  <= high_d;
      done_q  <= done_d;
      buf_q   <= buf_d;
    end
  end

  // result queue: output register plus skid entry
  res_t out_q, skid_q;
  logic push, pop;

  assign push = advance && emit;
  assign pop  = ov_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (!ov_q || pop) begin
      ov_q <= sv_q || push;
      sv_q <= sv_q && push;
    end else if (push) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || pop) begin
      if (sv_q) begin
        out_q <= skid_q;
        if (push) skid_q <= res_new;
      end else if (push) begin
        out_q <= res_new;
      end
    end else if (push) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o    = ov_q;
  assign ok_o           = out_q.ok;
  assign bytes_parsed_o = out_q.bytes_parsed;
  assign value_o        = out_q.value;

  // checks
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (bytes_parsed_o == '0) && (value_o == '0))
    else $error("failed token carries nonzero count or value");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("skid entry held while output register empty");

  a_done_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= MAX_CNT)
    else $error("byte count above maximum");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chv_q && sv_q) |=> chv_q)
    else $error("input word lost while queue full");

endmodule
